// File: sv/fcrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcrc_pkg
// Shared types and constants for the frame CRC-16 / byte checksum block.
// ----------------------------------------------------------------------------
package fcrc_pkg;

   localparam int unsigned CRC_W = 16;
   localparam int unsigned SUM_W = 8;

   // CCITT x^16+x^12+x^5+1, top bit implied
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   localparam logic KIND_CRC = 1'b0;
   localparam logic KIND_SUM = 1'b1;

   typedef struct packed {
      logic             kind;
      logic [CRC_W-1:0] value;
   } result_type;

   typedef struct packed {
      logic shift_en;
      logic data_bit;
      logic sum_clear;
   } core_ctrl_type;

   typedef struct packed {
      logic             frame_done;  // this shift closed a frame
      logic [CRC_W-1:0] frame_crc;   // remainder after this shift
      logic             frame_open;  // bits held in the frame after this cycle
      logic [SUM_W-1:0] sum;         // running sum of complemented CRC bytes
   } core_stat_type;

endpackage
`default_nettype wire

// File: sv/frame_crc16_with_checksum_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_crc16_with_checksum_top
// Cuts a byte stream into FRAME_BITS-bit frames, emits the CRC-16 of each
// frame and, on the final byte, the two's complement byte checksum.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_data_byte[7:0], req_final_byte
//   rsp      out  rsp_valid/rsp_stall  rsp_result_kind, rsp_result_value[15:0],
//                                      rsp_run_end
//
// Steps: accept, shift the byte in (one bit a cycle through the CRC unit),
//   on a final byte pad any open frame and form the checksum, then emit
//   each result beat (none when the list is empty), waiting while
//   rsp_stall holds the output register.
// The single bit-serial CRC unit sets the rate; req_stall is high from accept
//   until the last result beat is loaded into the output register.
// Reset is synchronous and clears CRC, bit count, sum and any held result.
// The output register lets the next byte be taken while a beat still waits.
//
module frame_crc16_with_checksum_top #(
   parameter int unsigned FRAME_BITS = 100
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_final_byte,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_result_kind,
   output logic [15:0] rsp_result_value,
   output logic        rsp_run_end
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PAD,
      ST_CHECK,
      ST_EMIT
   } state_type;

   localparam logic [1:0] LEN_FULL = 2'd3;   // more results than one call returns

   state_type               state_ff, state_in;
   logic [7:0]              byte_ff, byte_in;
   logic                    final_ff, final_in;
   logic [2:0]              bidx_ff, bidx_in;
   logic [1:0]              len_ff, len_in;
   logic                    eidx_ff, eidx_in;
   logic                    held_valid_ff, held_valid_in;
   fcrc_pkg::result_type    held_ff, held_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   fcrc_pkg::result_type    rsp_data_ff, rsp_data_in;
   logic                    rsp_run_end_ff, rsp_run_end_in;

   // result list for the current beat: slot 2 becomes the held result
   fcrc_pkg::result_type    slot_ff [3];
   logic                    slot_wr_en;
   logic [1:0]              slot_wr_idx;
   fcrc_pkg::result_type    slot_wr_data;

   fcrc_pkg::core_ctrl_type ctrl;
   fcrc_pkg::core_stat_type stat;

   logic                    push;
   fcrc_pkg::result_type    push_data;
   logic [1:0]              n_emit;
   logic                    out_free;

   fcrc_core #(
      .FRAME_BITS (FRAME_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat)
   );

   assign n_emit   = (len_ff == LEN_FULL) ? 2'd2 : len_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      byte_in        = byte_ff;
      final_in       = final_ff;
      bidx_in        = bidx_ff;
      len_in         = len_ff;
      eidx_in        = eidx_ff;
      held_valid_in  = held_valid_ff;
      held_in        = held_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      rsp_run_end_in = rsp_run_end_ff;
      ctrl           = '0;
      push           = 1'b0;
      push_data      = '0;
      slot_wr_en     = 1'b0;
      slot_wr_idx    = len_ff;
      slot_wr_data   = push_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               byte_in       = req_data_byte;
               final_in      = req_final_byte;
               bidx_in       = 3'd7;
               eidx_in       = 1'b0;
               held_valid_in = 1'b0;
               state_in      = ST_SHIFT;
               // a result deferred by the previous beat goes out first
               if (held_valid_ff) begin
                  slot_wr_en   = 1'b1;
                  slot_wr_idx  = 2'd0;
                  slot_wr_data = held_ff;
                  len_in       = 2'd1;
               end else begin
                  len_in = 2'd0;
               end
            end
         end
         ST_SHIFT: begin
            ctrl.shift_en = 1'b1;
            ctrl.data_bit = byte_ff[bidx_ff];
            push          = stat.frame_done;
            push_data     = '{kind: fcrc_pkg::KIND_CRC, value: stat.frame_crc};
            if (bidx_ff == 3'd0) begin
               if (!final_ff) begin
                  state_in = ST_EMIT;
               end else if (stat.frame_open) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_CHECK;
               end
            end else begin
               bidx_in = bidx_ff - 3'd1;
            end
         end
         ST_PAD: begin
            ctrl.shift_en = 1'b1;
            ctrl.data_bit = 1'b0;
            push          = stat.frame_done;
            push_data     = '{kind: fcrc_pkg::KIND_CRC, value: stat.frame_crc};
            if (stat.frame_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            ctrl.sum_clear = 1'b1;
            push           = 1'b1;
            push_data      = '{kind:  fcrc_pkg::KIND_SUM,
                               value: {8'h00, 8'(8'd0 - stat.sum)}};
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (n_emit == 2'd0) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_data_in    = slot_ff[{1'b0, eidx_ff}];
               rsp_run_end_in = ({1'b0, eidx_ff} == n_emit - 2'd1);
               if (rsp_run_end_in) begin
                  state_in      = ST_IDLE;
                  held_valid_in = (len_ff == LEN_FULL);
                  held_in       = slot_ff[2];
               end else begin
                  eidx_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // results past the third are dropped, as only one can be held
      if (push && (len_ff != LEN_FULL)) begin
         slot_wr_en   = 1'b1;
         slot_wr_idx  = len_ff;
         slot_wr_data = push_data;
         len_in       = len_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         len_ff         <= '0;
         eidx_ff        <= 1'b0;
         bidx_ff        <= '0;
         held_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_run_end_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         len_ff         <= len_in;
         eidx_ff        <= eidx_in;
         bidx_ff        <= bidx_in;
         held_valid_ff  <= held_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_run_end_ff <= rsp_run_end_in;
      end
      byte_ff     <= byte_in;
      final_ff    <= final_in;
      held_ff     <= held_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (slot_wr_en) begin
         slot_ff[slot_wr_idx] <= slot_wr_data;
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_data_ff.kind;
   assign rsp_result_value = rsp_data_ff.value;
   assign rsp_run_end      = rsp_run_end_ff;

   // ---- assertions ----------------------------------------------------------

   // list starts with the deferred result only if one was held
   a_accept_len: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (len_ff == {1'b0, $past(held_valid_ff)}))
      else $error("result list not primed correctly on accept");

   // checksum step always leaves at least one result to send
   a_check_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |=> (len_ff != 2'd0))
      else $error("checksum missing from result list");

   // the second beat sent in a run is marked as the last one
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && (n_emit != 2'd0) && out_free && (eidx_ff == 1'b1))
      |=> rsp_run_end_ff)
      else $error("second beat of a run not marked as last");

endmodule
`default_nettype wire

// File: sv/fcrc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcrc_core
// Bit-serial CRC-16 unit with frame bit counter and checksum accumulator.
// ----------------------------------------------------------------------------
module fcrc_core #(
   parameter int unsigned FRAME_BITS = 100
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire fcrc_pkg::core_ctrl_type ctrl,
   output fcrc_pkg::core_stat_type stat
);

   localparam int unsigned CntW = $clog2(FRAME_BITS + 1);

   logic [fcrc_pkg::CRC_W-1:0] crc_ff, crc_in, crc_step;
   logic [CntW-1:0]            cnt_ff, cnt_in, cnt_step;
   logic [fcrc_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic                       done;

   always_comb begin
      crc_step = {crc_ff[fcrc_pkg::CRC_W-2:0], 1'b0}
               ^ ((crc_ff[fcrc_pkg::CRC_W-1] ^ ctrl.data_bit) ? fcrc_pkg::CRC_POLY
                                                                : '0);
      cnt_step = cnt_ff + CntW'(1);
      done     = ctrl.shift_en && (cnt_step == CntW'(FRAME_BITS));

      crc_in = crc_ff;
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      if (ctrl.shift_en) begin
         if (done) begin
            crc_in = '0;
            cnt_in = '0;
            sum_in = sum_ff + (~crc_step[7:0]) + (~crc_step[15:8]);
         end else begin
            crc_in = crc_step;
            cnt_in = cnt_step;
         end
      end
      if (ctrl.sum_clear) begin
         sum_in = '0;
      end

      stat.frame_done = done;
      stat.frame_crc  = crc_step;
      stat.frame_open = (cnt_in != '0);
      stat.sum        = sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
         cnt_ff <= '0;
         sum_ff <= '0;
      end else begin
         crc_ff <= crc_in;
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
      end
   end

endmodule
`default_nettype wire

// File: sim/frame_crc16_with_checksum_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_crc16_with_checksum_top_test
// Self-checking bench for the frame CRC-16 / byte checksum block. Byte streams
// go in under random bursts and gaps. A tracker works out the frame CRC and
// checksum beats each byte should give. Every result beat is compared with
// the oldest beat still due, while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module frame_crc16_with_checksum_top_test;

   localparam int unsigned FRAME_BITS = 100;
   localparam int          NUM_BYTES  = 1550;

   // one expected result beat
   typedef struct {
      logic        kind;
      logic [15:0] value;
      logic        run_end;
   } crc_beat_type;

   // ------------------------------------------------------------------------
   // Tracker: mirrors the stream state, queues the beats each byte is owed
   // ------------------------------------------------------------------------
   class crc_sum_tracker;
      logic [15:0]  crc_rem;
      int unsigned  bits_in_frame;
      logic [7:0]   byte_sum;
      bit           deferred_ok;
      crc_beat_type deferred;
      crc_beat_type step_beats[$];
      crc_beat_type due_beats[$];
      int           fail_count;

      function new();
         crc_rem       = '0;
         bits_in_frame = 0;
         byte_sum      = '0;
         deferred_ok   = 0;
         fail_count    = 0;
      endfunction

      function void shift_in(logic b);
         logic fb;
         fb = crc_rem[15] ^ b;
         crc_rem = {crc_rem[14:0], 1'b0} ^ (fb ? fcrc_pkg::CRC_POLY : 16'h0000);
         bits_in_frame++;
      endfunction

      function void close_frame();
         crc_beat_type cb;
         cb.kind    = fcrc_pkg::KIND_CRC;
         cb.value   = crc_rem;
         cb.run_end = 1'b0;
         step_beats = {step_beats, cb};
         byte_sum      = byte_sum + ~crc_rem[7:0];
         byte_sum      = byte_sum + ~crc_rem[15:8];
         crc_rem       = '0;
         bits_in_frame = 0;
      endfunction

      // accepted input beat
      function void note_byte(logic [7:0] data, logic last);
         crc_beat_type cb;
         logic [7:0] chk;
         int n;
         step_beats.delete();
         // a checksum held back from the previous byte goes out first
         if (deferred_ok) begin
            step_beats = {step_beats, deferred};
            deferred_ok = 0;
         end
         for (int i = 7; i >= 0; i--) begin
            shift_in(data[i]);
            if (bits_in_frame >= FRAME_BITS)
               close_frame();
         end
         if (last) begin
            if (bits_in_frame > 0) begin
               while (bits_in_frame < FRAME_BITS)
                  shift_in(1'b0);
               close_frame();
            end
            chk        = 8'h00 - byte_sum;
            cb.kind    = fcrc_pkg::KIND_SUM;
            cb.value   = {8'h00, chk};
            cb.run_end = 1'b0;
            step_beats = {step_beats, cb};
            byte_sum = '0;
         end
         // two beats per byte at most; a third waits for the next byte
         n = (step_beats.size() < 2) ? step_beats.size() : 2;
         if (step_beats.size() > 2) begin
            deferred    = step_beats[2];
            deferred_ok = 1;
         end
         for (int k = 0; k < n; k++) begin
            cb = step_beats[k];
            cb.run_end = (k == n - 1);
            due_beats = {due_beats, cb};
         end
      endfunction

      // accepted result beat
      function void check_beat(logic kind, logic [15:0] value, logic run_end);
         crc_beat_type eb;
         if (due_beats.size() == 0) begin
            $error("unexpected result beat: kind %0d value %h", kind, value);
            fail_count++;
            return;
         end
         eb = due_beats.pop_front();
         if (kind !== eb.kind) begin
            $error("result_kind: expected %0d, got %0d", eb.kind, kind);
            fail_count++;
         end
         if (value !== eb.value) begin
            $error("result_value: expected %h, got %h", eb.value, value);
            fail_count++;
         end
         if (run_end !== eb.run_end) begin
            $error("run_end: expected %0d, got %0d", eb.run_end, run_end);
            fail_count++;
         end
      endfunction

      function int outstanding();
         return due_beats.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Block and its wires
   // ------------------------------------------------------------------------
   logic        clock;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte  = 8'h00;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic        rsp_result_kind;
   logic [15:0] rsp_result_value;
   logic        rsp_run_end;

   frame_crc16_with_checksum_top #(
      .FRAME_BITS(FRAME_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_final_byte  (req_final_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_result_value(rsp_result_value),
      .rsp_run_end     (rsp_run_end)
   );

   crc_sum_tracker tracker = new();

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: well beyond the slowest legal run (every byte padding a frame,
   // heavy result stalls, long sender gaps).
   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Result side: stall pattern in modes of random length, check each beat.
   // Outputs are read in the active region of the edge, i.e. pre-edge values.
   // ------------------------------------------------------------------------
   int stall_mode = 0;
   int mode_left  = 0;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_beat(rsp_result_kind, rsp_result_value, rsp_run_end);
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(16, 400);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;                           // free-flowing
         1: rsp_stall <= ($urandom_range(0, 3) == 0);    // light
         2: rsp_stall <= ($urandom_range(0, 3) != 0);    // heavy
         default: rsp_stall <= ((mode_left % 32) < 12); // long blocks
      endcase
   end

   // ------------------------------------------------------------------------
   // Input side: bursts of random length, random gaps between them
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int bytes_sent = 0;

   task automatic pace();
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         // now and then a long run with no idling at all
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
      end
   endtask

   task automatic send_byte(input logic [7:0] data, input logic last);
      pace();
      req_valid      <= 1'b1;
      req_data_byte  <= data;
      req_final_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_byte(data, last);
      burst_left--;
      bytes_sent++;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one stream of len beats, the last one marked final
   task automatic send_stream(input int len);
      for (int i = 0; i < len; i++)
         send_byte(pick_byte(), i == len - 1);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int len;
      int drain;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // single final bytes: the rest of the frame is padding
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b1);
      // 13 bytes: frame closes mid-byte on the final byte, so the partial
      // frame is padded too and the checksum is held back
      for (int i = 0; i < 12; i++)
         send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      // held checksum goes out ahead of these bytes' own beats
      send_byte(8'h80, 1'b1);
      send_byte(8'h01, 1'b1);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hA5, 1'b1);

      // random streams; frame-boundary and mid-byte endings weighted up
      while (bytes_sent < NUM_BYTES) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: len = $urandom_range(1, 40);
            4:          len = 25 * $urandom_range(1, 2);      // exact boundary
            5:          len = 25 * $urandom_range(0, 1) + 13; // ends mid-byte
            6, 7:       len = $urandom_range(1, 3);
            default:    len = $urandom_range(1, 100);
         endcase
         if (len > NUM_BYTES - bytes_sent)
            len = NUM_BYTES - bytes_sent;
         send_stream(len);
      end
      req_valid <= 1'b0;

      drain = 0;
      while (tracker.outstanding() != 0 && drain < 200_000) begin
         @(posedge clock);
         drain++;
      end
      // room for any stray beat from the pad and checksum cycles
      repeat (400) @(posedge clock);

      if (tracker.outstanding() != 0) begin
         $error("%0d result beats never arrived", tracker.outstanding());
         tracker.fail_count++;
      end
      if (tracker.fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
